FILE: rtl/core/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// shared constants and types for the tlb page table translator: address
// split, tlb geometry, counter width and the controller/datapath interface
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

  // address split
  localparam int unsigned PageBits   = 8;
  localparam int unsigned OffsetBits = 8;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned PageCount  = 1 << PageBits;
  localparam int unsigned FreeW      = PageBits + 1;

  // tlb geometry
  localparam int unsigned TlbEntries = 16;
  localparam int unsigned FillW      = $clog2(TlbEntries + 1);

  // running totals
  localparam int unsigned CountW = 32;

  // controller state
  typedef enum logic [0:0] {
    StIdle   = 1'b0,
    StLookup = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming address and start the page table read
    logic commit;   // update state and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// generic single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  wire logic [Width-1:0]           wr_data_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(Depth)-1:0]   rd_addr_i,
  output logic      [Width-1:0]           rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// sequencer: takes one address transaction, then commits its translation
// once the result register can accept it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  dp_status_t      status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLookup;
        end
      end
      StLookup: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlbpt_dp.sv
// ----------------------------------------------------------------------------
// tlbpt_dp
// datapath: address register, fifo tlb with parallel tag compare, page valid
// bits, page frame ram, free frame counter, saturating totals, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_dp
  import tlbpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_status_t                status_o,
  input  wire logic [AddrW-1:0]     logical_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [AddrW-1:0]     phys_addr_o,
  output logic                      tlb_hit_o,
  output logic                      page_fault_o,
  output logic      [CountW-1:0]    address_total_o,
  output logic      [CountW-1:0]    hit_total_o,
  output logic      [CountW-1:0]    fault_total_o
);

  logic [AddrW-1:0]      addr_q;
  logic [PageBits-1:0]   page;
  logic [OffsetBits-1:0] offset;

  logic [PageBits-1:0]   tag_q   [TlbEntries];
  logic [PageBits-1:0]   frame_q [TlbEntries];
  logic [FillW-1:0]      fill_q;

  logic [PageCount-1:0]  page_valid_q;
  logic [FreeW-1:0]      next_free_q;

  logic [CountW-1:0]     addr_cnt_q, hit_cnt_q, fault_cnt_q;

  logic                  out_valid_q;
  logic [AddrW-1:0]      phys_q;
  logic                  hit_q, fault_q;

  logic [TlbEntries-1:0] match;
  logic                  tlb_hit;
  logic [PageBits-1:0]   tlb_frame;
  logic                  fault;
  logic [PageBits-1:0]   new_frame;
  logic [PageBits-1:0]   pt_frame;
  logic [PageBits-1:0]   frame;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (&v) ? v : v + CountW'(1);
  endfunction

  // address split
  assign page   = addr_q[OffsetBits +: PageBits];
  assign offset = addr_q[OffsetBits-1:0];

  // capture the address transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= logical_address_i;
    end
  end

  // parallel tag compare over the filled slots
  always_comb begin
    for (int i = 0; i < TlbEntries; i++) begin
      match[i] = (FillW'(i) < fill_q) && (tag_q[i] == page);
    end
  end

  // newest matching slot wins
  always_comb begin
    tlb_hit   = 1'b0;
    tlb_frame = '0;
    for (int i = TlbEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        tlb_hit   = 1'b1;
        tlb_frame = frame_q[i];
      end
    end
  end

  // miss handling
  assign fault     = !tlb_hit && !page_valid_q[page];
  assign new_frame = next_free_q[PageBits-1:0];

  // page frame store, read issued with the capture
  tlbpt_ram #(
    .Width (PageBits),
    .Depth (PageCount)
  ) u_page_frame (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.commit && fault),
    .wr_addr_i (page),
    .wr_data_i (new_frame),
    .rd_en_i   (cmd_i.capture),
    .rd_addr_i (logical_address_i[OffsetBits +: PageBits]),
    .rd_data_o (pt_frame)
  );

  // frame source
  always_comb begin
    priority if (tlb_hit) begin
      frame = tlb_frame;
    end else if (fault) begin
      frame = new_frame;
    end else begin
      frame = pt_frame;
    end
  end

  // tlb shift line, newest at slot 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fault) begin
      tag_q[0]   <= page;
      frame_q[0] <= new_frame;
      for (int i = 1; i < TlbEntries; i++) begin
        tag_q[i]   <= tag_q[i-1];
        frame_q[i] <= frame_q[i-1];
      end
    end
  end

  // tlb fill, page valid bits, free frame and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      page_valid_q <= '0;
      next_free_q  <= '0;
      addr_cnt_q   <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      addr_cnt_q <= sat_inc(addr_cnt_q);
      if (tlb_hit) begin
        hit_cnt_q <= sat_inc(hit_cnt_q);
      end
      if (fault) begin
        fault_cnt_q        <= sat_inc(fault_cnt_q);
        page_valid_q[page] <= 1'b1;
        if (next_free_q < FreeW'(PageCount)) begin
          next_free_q <= next_free_q + FreeW'(1);
        end
        if (fill_q < FillW'(TlbEntries)) begin
          fill_q <= fill_q + FillW'(1);
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      phys_q  <= {frame, offset};
      hit_q   <= tlb_hit;
      fault_q <= fault;
    end
  end

  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign phys_addr_o         = phys_q;
  assign tlb_hit_o           = hit_q;
  assign page_fault_o        = fault_q;
  assign address_total_o     = addr_cnt_q;
  assign hit_total_o         = hit_cnt_q;
  assign fault_total_o       = fault_cnt_q;

endmodule

`default_nettype wire

FILE: rtl/core/tlb_page_table_translator_unit.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit
// demand paged address translator with a 16 entry fifo tlb
// ----------------------------------------------------------------------------
// Each address transaction is handled in the idle state, where the accepting
// cycle latches the address and starts the page table ram read, then in the
// lookup state, which does the parallel tlb compare, the fault decision and
// the state update and loads the result register, from which the result is
// offered. If an earlier result still waits in the result register, the
// lookup state holds until the waiting result is taken. A new address is
// taken only after the previous one is committed to the result register;
// the result register lets the next address in while the previous result
// still waits. Faults push the page into the tlb front, dropping the oldest
// entry when full; page table hits leave the tlb unchanged. Totals saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator_unit
  import tlbpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [AddrW-1:0]     logical_address_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [AddrW-1:0]     phys_addr_o,
  output logic                      tlb_hit_o,
  output logic                      page_fault_o,
  output logic      [CountW-1:0]    address_total_o,
  output logic      [CountW-1:0]    hit_total_o,
  output logic      [CountW-1:0]    fault_total_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // translation datapath
  tlbpt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .phys_addr_o        (phys_addr_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .address_total_o    (address_total_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

endmodule

`default_nettype wire
